// File: src/roa_pkg.sv
// Shared types, register indexes, mode codes and drive constants for the rover autopilot.
package roa_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CFG_FRONT_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIDE_LIMIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ROLL    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PITCH   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHARP_YAW   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPIN_YAW    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_REVERSE_MS  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPIN_MS     = 3'd7;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_FWD   = 3'd1;
  localparam logic [2:0] MODE_FRONT = 3'd2;
  localparam logic [2:0] MODE_LEFT  = 3'd3;
  localparam logic [2:0] MODE_RIGHT = 3'd4;

  localparam logic [1:0] CMD_KEEP = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  localparam logic signed [7:0] SPEED_FWD  = 8'sd60;
  localparam logic signed [7:0] SPEED_SIDE = 8'sd40;
  localparam logic signed [7:0] SPEED_REV  = -8'sd50;
  localparam logic [6:0]        YAW_MAX    = 7'd100;

  typedef struct packed {
    logic [9:0]  front_limit_cm;
    logic [9:0]  side_limit_cm;
    logic [10:0] max_roll_tenths;
    logic [10:0] max_pitch_tenths;
    logic [6:0]  sharp_yaw;
    logic [6:0]  spin_yaw;
    logic [15:0] reverse_ms;
    logic [15:0] spin_ms;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         front_cm;
    logic [9:0]         left_cm;
    logic [9:0]         right_cm;
    logic signed [11:0] roll_tenths;
    logic signed [11:0] pitch_tenths;
    logic [31:0]        now_ms;
    logic [1:0]         enable_cmd;
  } smp_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  mode;
    logic [31:0] start;
  } state_t;

  typedef struct packed {
    logic              drive_valid;
    logic signed [7:0] drive_speed;
    logic signed [7:0] drive_yaw;
    logic              stop_motor;
    logic              emergency_stop;
    logic [2:0]        mode;
    logic              enabled;
  } res_t;

endpackage

// File: src/roa_cfg_regs.sv
// Configuration register file for the rover autopilot.
module roa_cfg_regs import roa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FRONT_LIMIT: cfg_d.front_limit_cm   = cfg_wdata_i[9:0];
        CFG_SIDE_LIMIT:  cfg_d.side_limit_cm    = cfg_wdata_i[9:0];
        CFG_MAX_ROLL:    cfg_d.max_roll_tenths  = cfg_wdata_i[10:0];
        CFG_MAX_PITCH:   cfg_d.max_pitch_tenths = cfg_wdata_i[10:0];
        CFG_SHARP_YAW:   cfg_d.sharp_yaw        = cfg_wdata_i[6:0];
        CFG_SPIN_YAW:    cfg_d.spin_yaw         = cfg_wdata_i[6:0];
        CFG_REVERSE_MS:  cfg_d.reverse_ms       = cfg_wdata_i[15:0];
        CFG_SPIN_MS:     cfg_d.spin_ms          = cfg_wdata_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_limit_cm   <= 10'd30;
      cfg_q.side_limit_cm    <= 10'd20;
      cfg_q.max_roll_tenths  <= 11'd350;
      cfg_q.max_pitch_tenths <= 11'd500;
      cfg_q.sharp_yaw        <= 7'd80;
      cfg_q.spin_yaw         <= 7'd90;
      cfg_q.reverse_ms       <= 16'd1000;
      cfg_q.spin_ms          <= 16'd1500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/roa_step.sv
// Next-state and motor command logic for one sensor sample.
module roa_step import roa_pkg::*; (
  input  smp_t   smp_i,
  input  cfg_t   cfg_i,
  input  state_t st_i,
  output state_t st_o,
  output res_t   res_o
);

  logic              en_cmd;
  logic [11:0]       abs_roll, abs_pitch;
  logic              tilt;
  logic              front_blk, left_blk, right_blk;
  logic [12:0]       side_lim6, left5, right5;
  logic              left_clr, right_clr;
  logic [31:0]       elapsed;
  logic [16:0]       spin_end;
  logic [6:0]        sharp_sat, spin_sat;
  logic signed [7:0] sharp_pos, sharp_neg, spin_pos, spin_neg;

  always_comb begin
    en_cmd = st_i.en;
    if (smp_i.enable_cmd == CMD_ON) begin
      en_cmd = 1'b1;
    end else if (smp_i.enable_cmd == CMD_OFF) begin
      en_cmd = 1'b0;
    end
  end

  assign abs_roll  = smp_i.roll_tenths[11] ? (~smp_i.roll_tenths + 12'd1)
                                           : smp_i.roll_tenths;
  assign abs_pitch = smp_i.pitch_tenths[11] ? (~smp_i.pitch_tenths + 12'd1)
                                            : smp_i.pitch_tenths;
  assign tilt = (abs_roll > {1'b0, cfg_i.max_roll_tenths}) ||
                (abs_pitch > {1'b0, cfg_i.max_pitch_tenths});

  assign front_blk = smp_i.front_cm < cfg_i.front_limit_cm;
  assign left_blk  = smp_i.left_cm  < cfg_i.side_limit_cm;
  assign right_blk = smp_i.right_cm < cfg_i.side_limit_cm;

  // clearance: d * 5 > limit * 6
  assign side_lim6 = {1'b0, cfg_i.side_limit_cm, 2'b00} + {2'b00, cfg_i.side_limit_cm, 1'b0};
  assign left5     = {1'b0, smp_i.left_cm, 2'b00} + {3'b000, smp_i.left_cm};
  assign right5    = {1'b0, smp_i.right_cm, 2'b00} + {3'b000, smp_i.right_cm};
  assign left_clr  = left5 > side_lim6;
  assign right_clr = right5 > side_lim6;

  assign elapsed  = smp_i.now_ms - st_i.start;
  assign spin_end = {1'b0, cfg_i.reverse_ms} + {1'b0, cfg_i.spin_ms};

  assign sharp_sat = (cfg_i.sharp_yaw > YAW_MAX) ? YAW_MAX : cfg_i.sharp_yaw;
  assign spin_sat  = (cfg_i.spin_yaw > YAW_MAX) ? YAW_MAX : cfg_i.spin_yaw;
  assign sharp_pos = $signed({1'b0, sharp_sat});
  assign sharp_neg = -sharp_pos;
  assign spin_pos  = $signed({1'b0, spin_sat});
  assign spin_neg  = -spin_pos;

  always_comb begin
    st_o                 = st_i;
    st_o.en              = en_cmd;
    res_o.drive_valid    = 1'b0;
    res_o.drive_speed    = '0;
    res_o.drive_yaw      = '0;
    res_o.stop_motor     = 1'b0;
    res_o.emergency_stop = 1'b0;
    if (!en_cmd) begin
      if (st_i.mode != MODE_IDLE) begin
        res_o.stop_motor = 1'b1;
        st_o.mode        = MODE_IDLE;
      end
    end else if (tilt) begin
      res_o.emergency_stop = 1'b1;
      st_o.en              = 1'b0;
      st_o.mode            = MODE_IDLE;
    end else begin
      case (st_i.mode)
        MODE_FWD: begin
          res_o.drive_valid = 1'b1;
          res_o.drive_speed = SPEED_FWD;
          if (front_blk) begin
            res_o.stop_motor = 1'b1;
            st_o.mode        = MODE_FRONT;
            st_o.start       = smp_i.now_ms;
          end else if (left_blk) begin
            st_o.mode = MODE_LEFT;
          end else if (right_blk) begin
            st_o.mode = MODE_RIGHT;
          end
        end
        MODE_LEFT, MODE_RIGHT: begin
          res_o.drive_valid = 1'b1;
          res_o.drive_speed = SPEED_SIDE;
          if (st_i.mode == MODE_LEFT) begin
            res_o.drive_yaw = sharp_pos;
            if (left_clr) st_o.mode = MODE_FWD;
          end else begin
            res_o.drive_yaw = sharp_neg;
            if (right_clr) st_o.mode = MODE_FWD;
          end
          // front obstacle overrides clearance and restarts the maneuver
          if (front_blk) begin
            st_o.mode  = MODE_FRONT;
            st_o.start = smp_i.now_ms;
          end
        end
        MODE_FRONT: begin
          if (elapsed < {16'd0, cfg_i.reverse_ms}) begin
            res_o.drive_valid = 1'b1;
            res_o.drive_speed = SPEED_REV;
          end else if (elapsed < {15'd0, spin_end}) begin
            res_o.drive_valid = 1'b1;
            res_o.drive_yaw   = (smp_i.left_cm > smp_i.right_cm) ? spin_neg : spin_pos;
          end else begin
            st_o.mode = MODE_FWD;
          end
        end
        default: begin
          st_o.mode = MODE_FWD;
        end
      endcase
    end
    res_o.mode    = st_o.mode;
    res_o.enabled = st_o.en;
  end

endmodule

// File: src/rover_obstacle_avoid_fsm_core.sv
// Top level of the rover obstacle-avoidance autopilot.
// One sensor word in, one motor command word out. A word passes an input
// register, is evaluated combinationally against the enable flag, mode and
// maneuver timer, and lands in a result register: out_valid_o rises as the
// word moves into the result register, and one word is taken every cycle
// while the output side keeps up. While a finished result waits, the input
// register takes at most one more word and then holds in_ready_o low. The
// state updates as each word moves into the result register. There is no
// post-reset clearing pass; configuration writes take effect next cycle.
module rover_obstacle_avoid_fsm_core import roa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [9:0]          front_cm_i,
  input  logic [9:0]          left_cm_i,
  input  logic [9:0]          right_cm_i,
  input  logic signed [11:0]  roll_tenths_i,
  input  logic signed [11:0]  pitch_tenths_i,
  input  logic [31:0]         now_ms_i,
  input  logic [1:0]          enable_cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                drive_valid_o,
  output logic signed [7:0]   drive_speed_o,
  output logic signed [7:0]   drive_yaw_o,
  output logic                stop_motor_o,
  output logic                emergency_stop_o,
  output logic [2:0]          mode_o,
  output logic                enabled_o
);

  cfg_t   cfg;
  smp_t   smp_q;
  logic   smp_valid_q;
  state_t st_q, st_d;
  res_t   res_d, res_q;
  logic   out_valid_q;
  logic   advance;

  roa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  roa_step u_step (
    .smp_i (smp_q),
    .cfg_i (cfg),
    .st_i  (st_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  assign advance    = smp_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !smp_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_ready_o) smp_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q.front_cm     <= front_cm_i;
      smp_q.left_cm      <= left_cm_i;
      smp_q.right_cm     <= right_cm_i;
      smp_q.roll_tenths  <= roll_tenths_i;
      smp_q.pitch_tenths <= pitch_tenths_i;
      smp_q.now_ms       <= now_ms_i;
      smp_q.enable_cmd   <= enable_cmd_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign drive_valid_o    = res_q.drive_valid;
  assign drive_speed_o    = res_q.drive_speed;
  assign drive_yaw_o      = res_q.drive_yaw;
  assign stop_motor_o     = res_q.stop_motor;
  assign emergency_stop_o = res_q.emergency_stop;
  assign mode_o           = res_q.mode;
  assign enabled_o        = res_q.enabled;

`ifndef SYNTHESIS
  a_estop_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && emergency_stop_o |-> !enabled_o && (mode_o == MODE_IDLE))
    else $error("emergency stop without disable and idle");

  a_no_drive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_valid_o |-> (drive_speed_o == 8'sd0) && (drive_yaw_o == 8'sd0))
    else $error("speed or yaw nonzero without drive command");

  a_state_tracks_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (mode_o == st_q.mode) && (enabled_o == st_q.en))
    else $error("result word disagrees with stored state");

  a_stop_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(stop_motor_o && emergency_stop_o))
    else $error("stop and emergency stop together");
`endif

endmodule
